@@ hw/rtl/pst_pkg.sv @@
`timescale 1ns / 1ps

package pst_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int TIME_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int COUNT_W     = $clog2(MAX_SENSORS + 1);
    localparam int S_TDATA_W   = 3 * TIME_W;
    localparam int M_TDATA_W   = ((TIME_W + INDEX_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0]  TIME_ONES = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SENSORS);

    // one sensor entry after the input register
    typedef struct packed {
        logic              never;
        logic              last;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] elapsed;
    } t_entry;

    typedef struct packed {
        logic [TIME_W-1:0]  wait_ms;
        logic [INDEX_W-1:0] index;
    } t_result;

endpackage

@@ hw/rtl/periodic_due_time_scan_unit.sv @@
`timescale 1ns / 1ps

// Scans a stream of sensor entries, one beat per sensor with tlast on the final
// one, and returns one beat per scan: a wait of 0 with the index of the first
// due sensor, or else the smallest remaining time (period minus the modular
// elapsed time) and its sensor. A last time of 0 counts as due. With no
// qualifying entry the wait is all ones and the previous index is repeated.
// Entries beyond MAX_SENSORS in one scan are ignored. One entry is taken every
// cycle unless a result waits on i_m_axis_tready; the result passes through an
// input register (which forms the elapsed time) and a result register.

module periodic_due_time_scan_unit
    import pst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // now_ms [31:0], period_ms [63:32], last_time_ms [95:64]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // wait_ms [31:0], sensor_index [35:32], zero pad above
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic              r_s1_valid;
    t_entry            r_s1;
    logic              r_out_valid;
    t_result           r_out;
    t_result           result;
    logic              s1_go;
    logic              s_beat;
    logic [TIME_W-1:0] in_now, in_period, in_last;

    assign in_now    = i_s_axis_tdata[TIME_W-1:0];
    assign in_period = i_s_axis_tdata[2*TIME_W-1:TIME_W];
    assign in_last   = i_s_axis_tdata[3*TIME_W-1:2*TIME_W];

    assign s1_go  = r_s1_valid && (!r_s1.last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign s_beat = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_s1.never   <= (in_last == '0);
            r_s1.last    <= i_s_axis_tlast;
            r_s1.period  <= in_period;
            r_s1.elapsed <= in_now - in_last;
        end
    end

    pst_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_entry  (r_s1),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out.index, r_out.wait_ms});

endmodule

@@ hw/rtl/pst_tracker.sv @@
`timescale 1ns / 1ps

module pst_tracker
    import pst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_entry  i_entry,
    output t_result o_result
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0]  r_best, n_best;
    logic               r_due, n_due;
    logic [INDEX_W-1:0] r_chosen, n_chosen;

    logic               due_now;
    logic [TIME_W-1:0]  remain;
    logic [INDEX_W-1:0] idx;

    assign due_now = i_entry.never || (i_entry.elapsed > i_entry.period);
    assign remain  = i_entry.period - i_entry.elapsed;
    assign idx     = INDEX_W'(r_count);

    always_comb begin
        n_count  = r_count;
        n_best   = r_best;
        n_due    = r_due;
        n_chosen = r_chosen;
        if (r_count < COUNT_MAX) begin
            if (!r_due) begin
                if (due_now) begin
                    n_due    = 1'b1;
                    n_best   = '0;
                    n_chosen = idx;
                end else if (remain < r_best) begin
                    n_best   = remain;
                    n_chosen = idx;
                end
            end
            n_count = r_count + 1'b1;
        end
    end

    assign o_result.wait_ms = n_due ? '0 : n_best;
    assign o_result.index   = n_chosen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_best   <= TIME_ONES;
            r_due    <= 1'b0;
            r_chosen <= '0;
        end else if (i_step) begin
            r_chosen <= n_chosen;
            if (i_entry.last) begin
                r_count <= '0;
                r_best  <= TIME_ONES;
                r_due   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_best  <= n_best;
                r_due   <= n_due;
            end
        end
    end

endmodule
